// ===== rtl/round_robin_thread_scheduler_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the thread scheduler
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_UNIT_MACROS_SVH

// implication checked on every edge outside reset
`define RRTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrts assertion failed");

// next-cycle implication checked on every edge outside reset
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrts assertion failed");

`endif

// ===== rtl/rrts_pkg.sv =====
// ---------------------------------------------------------------------------
// rrts_pkg
// Types and constants shared by the thread scheduler modules.
// ---------------------------------------------------------------------------
package rrts_pkg;

    localparam int unsigned THREADS_DEF = 16;
    localparam int unsigned QUANTUM_W   = 20;
    localparam logic [19:0] QUANTUM_RST = 20'd100;

    localparam logic [2:0] REQ_SPAWN = 3'd0;
    localparam logic [2:0] REQ_TERM  = 3'd1;
    localparam logic [2:0] REQ_BLOCK = 3'd2;
    localparam logic [2:0] REQ_RESUME = 3'd3;
    localparam logic [2:0] REQ_SLEEP = 3'd4;
    localparam logic [2:0] REQ_TICK  = 3'd5;
    localparam logic [2:0] REQ_QUERY = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_THR  = 3'd1;
    localparam logic [2:0] ST_ILLEGAL = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_MAIN_RST = 3'd4;

    localparam logic [1:0] MODE_READY   = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_BLOCKED = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  thread_id;
        logic [23:0] sleep_ticks;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  new_thread_id;
        logic [3:0]  running_id;
        logic [31:0] total_quanta;
        logic [31:0] thread_quanta;
    } t_rsp;

endpackage

// ===== rtl/round_robin_thread_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// round_robin_thread_scheduler_unit
// Round-robin thread table with ready queue, sleep timers and slice counts.
// ---------------------------------------------------------------------------
// Request channel: i_start with i_req is taken at an edge where o_busy is low.
// Each request gives one response word on o_rsp, marked by o_done for one
// cycle right after o_busy falls; the next request may be taken at that edge.
// Quantum register: i_cfg_valid/o_cfg_ready with i_cfg_data, ready while idle.
// One request at a time. A removal from mid-queue (block or terminate of
// a queued thread), a switch, a timed sleep and a preempting tick walk the
// ready queue entry by entry; every tick also walks the whole thread table.
// The queue and table memories each have one write and one read port with
// registered reads, and the queue keeps a linear layout.
// Reset: synchronous, active low; thread 0 is valid and running, quantum is
// 100, no clearing pass: per-entry flags mark written slice counts.
// Terminating thread 0 resets the table in the decode state; the quantum is kept.
// The receiver cannot stall: each response is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module round_robin_thread_scheduler_unit #(
    parameter int unsigned THREADS = rrts_pkg::THREADS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  rrts_pkg::t_req                 i_req,
    output logic                           o_done,
    output rrts_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rrts_pkg::QUANTUM_W-1:0] i_cfg_data
);
    localparam int unsigned IW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int unsigned CW = $clog2(THREADS + 1);
    localparam logic [CW-1:0] C_MAX = CW'(THREADS);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_DEC    = 15'b000000000000010,
        S_QRD    = 15'b000000000000100,
        S_SLRD   = 15'b000000000001000,
        S_SLWR   = 15'b000000000010000,
        S_RMRD   = 15'b000000000100000,
        S_RMWR   = 15'b000000001000000,
        S_POPRD  = 15'b000000010000000,
        S_POPWR  = 15'b000000100000000,
        S_SWRD   = 15'b000001000000000,
        S_SWWR   = 15'b000010000000000,
        S_TKRD   = 15'b000100000000000,
        S_TKWR   = 15'b001000000000000,
        S_TKEND  = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } t_state;

    t_state r_state;

    logic [rrts_pkg::QUANTUM_W-1:0] r_quantum;
    logic [THREADS-1:0]  r_valid, r_asleep, r_cnt_ok;
    logic [1:0]          r_mode [THREADS];
    logic [CW-1:0]       r_rcount, r_live;
    logic [IW-1:0]       r_cur;
    logic [31:0]         r_total;
    logic [19:0]         r_elapsed;
    rrts_pkg::t_req      r_req;
    logic [2:0]          r_status;
    logic [IW-1:0]       r_newid;
    logic [31:0]         r_tq;
    logic [CW-1:0]       r_i, r_k;
    logic [IW-1:0]       r_head;

    // queue memory
    logic          q_we;
    logic [IW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
    // table memory
    logic          t_we;
    logic [IW-1:0] t_waddr, t_raddr;
    logic [23:0]   t_wsleep, t_rsleep;
    logic [31:0]   t_wslices, t_rslices;

    rrts_fifo #(.THREADS(THREADS), .IW(IW)) u_fifo (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    rrts_table #(.THREADS(THREADS), .IW(IW)) u_table (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wsleep(t_wsleep),
        .i_wslices(t_wslices), .i_raddr(t_raddr), .o_rsleep(t_rsleep),
        .o_rslices(t_rslices)
    );

    logic          id_ok;
    logic [IW-1:0] id_ix;
    logic          known;
    logic [IW-1:0] free_ix;
    logic          free_any;
    logic          spawn_ok;
    logic [19:0]   elapsed_inc;
    logic [IW-1:0] tk_ix;
    logic          wake;

    // unwritten slice counts read as one for thread 0, zero elsewhere
    function automatic logic [31:0] slices_of(logic ok, logic [IW-1:0] ix,
                                              logic [31:0] mem);
        slices_of = ok ? mem : ((ix == '0) ? 32'd1 : 32'd0);
    endfunction

    always_comb begin
        id_ok = ({28'd0, r_req.thread_id} < 32'(THREADS));
        id_ix = IW'(r_req.thread_id);
        known = id_ok && r_valid[id_ix];
        free_ix = '0;
        free_any = 1'b0;
        for (int j = THREADS - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                free_ix = IW'(j);
                free_any = 1'b1;
            end
        end
        spawn_ok = (r_live < C_MAX) && free_any;
        elapsed_inc = r_elapsed + 20'd1;
    end

    assign tk_ix = IW'(r_i);
    assign wake  = (r_state == S_TKWR) && r_valid[tk_ix] && r_asleep[tk_ix]
                   && (t_rsleep <= 24'd1);

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    // memory control
    always_comb begin
        q_we = 1'b0; q_waddr = IW'(r_rcount); q_wdata = '0;
        q_raddr = IW'(r_i);
        t_we = 1'b0; t_waddr = '0; t_wsleep = t_rsleep;
        t_wslices = t_rslices; t_raddr = r_cur;
        unique case (r_state)
            S_DEC: begin
                unique case (r_req.req_type)
                    rrts_pkg::REQ_SPAWN: begin
                        if (spawn_ok) begin
                            q_we = (r_rcount < C_MAX); q_wdata = free_ix;
                            t_we = 1'b1; t_waddr = free_ix; t_wslices = 32'd0;
                        end
                    end
                    rrts_pkg::REQ_RESUME: begin
                        if (known && !r_asleep[id_ix]
                                && r_mode[id_ix] == rrts_pkg::MODE_BLOCKED) begin
                            q_we = (r_rcount < C_MAX); q_wdata = id_ix;
                        end
                    end
                    rrts_pkg::REQ_SLEEP: begin
                        if (r_cur != '0 && r_req.sleep_ticks == 24'd0) begin
                            q_we = (r_rcount < C_MAX); q_wdata = r_cur;
                        end
                    end
                    rrts_pkg::REQ_QUERY: t_raddr = id_ix;
                    default: ;
                endcase
            end
            S_SLWR: begin
                t_we = 1'b1; t_waddr = r_cur; t_wsleep = r_req.sleep_ticks;
                t_wslices = slices_of(r_cnt_ok[r_cur], r_cur, t_rslices);
            end
            S_RMWR: begin
                q_we = (q_rdata != id_ix); q_waddr = IW'(r_k); q_wdata = q_rdata;
            end
            S_POPWR: begin
                q_we = (r_i != '0); q_waddr = IW'(r_i - CW'(1)); q_wdata = q_rdata;
            end
            S_SWRD: t_raddr = r_head;
            S_SWWR: begin
                t_we = 1'b1; t_waddr = r_head;
                t_wslices = slices_of(r_cnt_ok[r_head], r_head, t_rslices) + 32'd1;
            end
            S_TKRD: t_raddr = tk_ix;
            S_TKWR: begin
                t_we = r_valid[tk_ix] && r_asleep[tk_ix];
                t_waddr = tk_ix;
                t_wsleep = (t_rsleep != 24'd0) ? t_rsleep - 24'd1 : 24'd0;
                if (wake && r_mode[tk_ix] == rrts_pkg::MODE_READY) begin
                    q_we = (r_rcount < C_MAX); q_wdata = tk_ix;
                end
            end
            S_TKEND: begin
                if (elapsed_inc >= r_quantum) begin
                    q_we = (r_rcount < C_MAX); q_wdata = r_cur;
                end
            end
            default: ;
        endcase
    end

    // state sequencing and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_quantum <= rrts_pkg::QUANTUM_RST;
            r_valid   <= THREADS'(1);
            r_asleep  <= '0;
            r_cnt_ok  <= '0;
            for (int j = 0; j < THREADS; j++) begin
                r_mode[j] <= (j == 0) ? rrts_pkg::MODE_RUNNING : rrts_pkg::MODE_READY;
            end
            r_rcount  <= '0;
            r_live    <= CW'(1);
            r_cur     <= '0;
            r_total   <= 32'd1;
            r_elapsed <= '0;
            o_done    <= 1'b0;
            r_i <= '0; r_k <= '0; r_head <= '0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) r_quantum <= i_cfg_data;
                    if (i_start) begin
                        r_req <= i_req; r_state <= S_DEC;
                        r_status <= rrts_pkg::ST_OK; r_newid <= '0; r_tq <= '0;
                    end
                end
                S_DEC: begin
                    r_state <= S_DONE;
                    unique case (r_req.req_type)
                        rrts_pkg::REQ_SPAWN: begin
                            if (!spawn_ok) begin
                                r_status <= rrts_pkg::ST_FULL;
                            end else begin
                                r_valid[free_ix] <= 1'b1;
                                r_mode[free_ix] <= rrts_pkg::MODE_READY;
                                r_asleep[free_ix] <= 1'b0;
                                r_cnt_ok[free_ix] <= 1'b1;
                                if (r_rcount < C_MAX) r_rcount <= r_rcount + CW'(1);
                                r_live <= r_live + CW'(1);
                                r_newid <= free_ix;
                            end
                        end
                        rrts_pkg::REQ_TERM: begin
                            if (!known) begin
                                r_status <= rrts_pkg::ST_NO_THR;
                            end else if (id_ix == '0) begin
                                r_status <= rrts_pkg::ST_MAIN_RST;
                                r_valid <= THREADS'(1); r_asleep <= '0;
                                r_cnt_ok <= '0;
                                for (int j = 0; j < THREADS; j++) begin
                                    r_mode[j] <= (j == 0) ? rrts_pkg::MODE_RUNNING
                                                          : rrts_pkg::MODE_READY;
                                end
                                r_rcount <= '0; r_live <= CW'(1); r_cur <= '0;
                                r_total <= 32'd1; r_elapsed <= '0;
                            end else begin
                                r_valid[id_ix] <= 1'b0; r_asleep[id_ix] <= 1'b0;
                                r_mode[id_ix] <= rrts_pkg::MODE_READY;
                                if (r_live != '0) r_live <= r_live - CW'(1);
                                if (!r_asleep[id_ix]
                                        && r_mode[id_ix] == rrts_pkg::MODE_RUNNING) begin
                                    r_i <= '0; r_state <= S_POPRD;
                                end else if (!r_asleep[id_ix]
                                        && r_mode[id_ix] == rrts_pkg::MODE_READY) begin
                                    r_i <= '0; r_k <= '0; r_state <= S_RMRD;
                                end
                            end
                        end
                        rrts_pkg::REQ_BLOCK: begin
                            if (!known) begin
                                r_status <= rrts_pkg::ST_NO_THR;
                            end else if (id_ix == '0) begin
                                r_status <= rrts_pkg::ST_ILLEGAL;
                            end else if (r_asleep[id_ix]) begin
                                r_mode[id_ix] <= rrts_pkg::MODE_BLOCKED;
                            end else if (r_mode[id_ix] == rrts_pkg::MODE_RUNNING) begin
                                r_mode[id_ix] <= rrts_pkg::MODE_BLOCKED;
                                r_i <= '0; r_state <= S_POPRD;
                            end else if (r_mode[id_ix] == rrts_pkg::MODE_READY) begin
                                r_mode[id_ix] <= rrts_pkg::MODE_BLOCKED;
                                r_i <= '0; r_k <= '0; r_state <= S_RMRD;
                            end
                        end
                        rrts_pkg::REQ_RESUME: begin
                            if (!known) begin
                                r_status <= rrts_pkg::ST_NO_THR;
                            end else if (r_asleep[id_ix]) begin
                                r_mode[id_ix] <= rrts_pkg::MODE_READY;
                            end else if (r_mode[id_ix] == rrts_pkg::MODE_BLOCKED) begin
                                r_mode[id_ix] <= rrts_pkg::MODE_READY;
                                if (r_rcount < C_MAX) r_rcount <= r_rcount + CW'(1);
                            end
                        end
                        rrts_pkg::REQ_SLEEP: begin
                            if (r_cur == '0) begin
                                r_status <= rrts_pkg::ST_ILLEGAL;
                            end else begin
                                r_mode[r_cur] <= rrts_pkg::MODE_READY;
                                if (r_req.sleep_ticks == 24'd0) begin
                                    if (r_rcount < C_MAX) r_rcount <= r_rcount + CW'(1);
                                    r_i <= '0; r_state <= S_POPRD;
                                end else begin
                                    r_asleep[r_cur] <= 1'b1;
                                    r_state <= S_SLRD;
                                end
                            end
                        end
                        rrts_pkg::REQ_TICK: begin
                            r_i <= '0; r_state <= S_TKRD;
                        end
                        rrts_pkg::REQ_QUERY: begin
                            if (!known) r_status <= rrts_pkg::ST_NO_THR;
                            else r_state <= S_QRD;
                        end
                        default: ;
                    endcase
                end
                S_QRD: begin
                    r_tq <= slices_of(r_cnt_ok[id_ix], id_ix, t_rslices);
                    r_state <= S_DONE;
                end
                S_SLRD: r_state <= S_SLWR;
                S_SLWR: begin
                    r_cnt_ok[r_cur] <= 1'b1;
                    r_i <= '0; r_state <= S_POPRD;
                end
                S_RMRD: begin
                    if (r_i >= r_rcount) begin
                        r_rcount <= r_k; r_state <= S_DONE;
                    end else begin
                        r_state <= S_RMWR;
                    end
                end
                S_RMWR: begin
                    r_i <= r_i + CW'(1);
                    if (q_rdata != id_ix) r_k <= r_k + CW'(1);
                    r_state <= S_RMRD;
                end
                S_POPRD: begin
                    if (r_rcount == '0) begin
                        r_head <= '0; r_state <= S_SWRD;
                    end else begin
                        r_state <= S_POPWR;
                    end
                end
                S_POPWR: begin
                    if (r_i == '0) r_head <= q_rdata;
                    r_i <= r_i + CW'(1);
                    if (r_i + CW'(1) >= r_rcount) begin
                        r_rcount <= r_rcount - CW'(1);
                        r_state <= S_SWRD;
                    end else begin
                        r_state <= S_POPRD;
                    end
                end
                S_SWRD: r_state <= S_SWWR;
                S_SWWR: begin
                    r_cur <= r_head; r_mode[r_head] <= rrts_pkg::MODE_RUNNING;
                    r_cnt_ok[r_head] <= 1'b1;
                    r_total <= r_total + 32'd1; r_elapsed <= '0;
                    r_state <= S_DONE;
                end
                S_TKRD: r_state <= S_TKWR;
                S_TKWR: begin
                    if (wake) begin
                        r_asleep[tk_ix] <= 1'b0;
                        if (r_mode[tk_ix] == rrts_pkg::MODE_READY && r_rcount < C_MAX)
                            r_rcount <= r_rcount + CW'(1);
                    end
                    r_i <= r_i + CW'(1);
                    if (r_i + CW'(1) == C_MAX) r_state <= S_TKEND;
                    else r_state <= S_TKRD;
                end
                S_TKEND: begin
                    r_elapsed <= elapsed_inc;
                    if (elapsed_inc >= r_quantum) begin
                        r_mode[r_cur] <= rrts_pkg::MODE_READY;
                        if (r_rcount < C_MAX) r_rcount <= r_rcount + CW'(1);
                        r_i <= '0; r_state <= S_POPRD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_done <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.status        = r_status;
    assign o_rsp.new_thread_id = 4'(r_newid);
    assign o_rsp.running_id    = 4'(r_cur);
    assign o_rsp.total_quanta  = r_total;
    assign o_rsp.thread_quanta = r_tq;

    `include "round_robin_thread_scheduler_unit_macros.svh"

    `RRTS_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, r_state == S_IDLE)
    `RRTS_ASSERT_IMPL(a_live_bound, i_clk, i_rst_n, 1'b1, r_live <= C_MAX)
    `RRTS_ASSERT_IMPL(a_main_valid, i_clk, i_rst_n, 1'b1, r_valid[0])
    `RRTS_ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, r_rcount <= C_MAX)
endmodule

// ===== rtl/rrts_fifo.sv =====
// ---------------------------------------------------------------------------
// rrts_fifo
// Ready queue memory: sync-read array, linear layout, one write and one read port.
// ---------------------------------------------------------------------------
module rrts_fifo #(
    parameter int unsigned THREADS = rrts_pkg::THREADS_DEF,
    parameter int unsigned IW = (THREADS > 1) ? $clog2(THREADS) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [IW-1:0] i_wdata,
    input  logic [IW-1:0] i_raddr,
    output logic [IW-1:0] o_rdata
);
    logic [IW-1:0] r_mem [THREADS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/rrts_table.sv =====
// ---------------------------------------------------------------------------
// rrts_table
// Per-thread sleep counter and slice counter memories, sync read.
// ---------------------------------------------------------------------------
module rrts_table #(
    parameter int unsigned THREADS = rrts_pkg::THREADS_DEF,
    parameter int unsigned IW = (THREADS > 1) ? $clog2(THREADS) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [23:0]   i_wsleep,
    input  logic [31:0]   i_wslices,
    input  logic [IW-1:0] i_raddr,
    output logic [23:0]   o_rsleep,
    output logic [31:0]   o_rslices
);
    logic [55:0] r_mem [THREADS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wsleep, i_wslices};
        end
        {o_rsleep, o_rslices} <= r_mem[i_raddr];
    end
endmodule
